// ===== sv/bpfa_pkg.sv =====
`timescale 1ns / 1ps

package bpfa_pkg;

	// Bitmap geometry
	localparam int unsigned DEPTH_DEFAULT = 8192;
	localparam int unsigned PAGE_SHIFT    = 12;   // 4 KiB pages
	localparam int unsigned BYTE_IDX_W    = 18;   // holds a byte index up to the largest depth
	localparam int unsigned FREE_W        = 17;

	localparam logic [FREE_W-1:0] FREE_MAX = '1;

	// Configuration register indexes
	localparam logic CFG_BITMAP_BYTES   = 1'b0;
	localparam logic CFG_RESERVED_PAGES = 1'b1;

	localparam logic [13:0] BITMAP_BYTES_RESET   = 14'd8192;
	localparam logic [16:0] RESERVED_PAGES_RESET = 17'd256;

	// Request codes
	localparam logic [1:0] REQ_ALLOC      = 2'd0;
	localparam logic [1:0] REQ_RELEASE    = 2'd1;
	localparam logic [1:0] REQ_FREE_RANGE = 2'd2;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_NO_FREE     = 2'd1,
		ST_BAD_RELEASE = 2'd2,
		ST_RESERVED    = 2'd3
	} bpfa_status_t;

	// Result of the shared byte unit
	typedef struct packed {
		logic [7:0] set_byte;   // byte with its lowest zero bit set
		logic [7:0] clr_byte;   // byte with the masked bits cleared
		logic [2:0] zero_bit;   // position of the lowest zero bit
		logic [3:0] hit_cnt;    // masked bits that were set
		logic       all_ones;   // byte is full
	} bpfa_byte_res_t;

endpackage

// ===== sv/bpfa_bitmap_ram.sv =====
`timescale 1ns / 1ps

module bpfa_bitmap_ram #(
	parameter int unsigned DEPTH = 8192,
	parameter int unsigned AW    = 13
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/bpfa_byte_unit.sv =====
`timescale 1ns / 1ps

module bpfa_byte_unit
	import bpfa_pkg::*;
(
	input  logic [7:0]     data,
	input  logic [2:0]     lo,
	input  logic [2:0]     hi,
	output bpfa_byte_res_t res
);

	logic [7:0] mask;
	logic [7:0] hits;
	logic [3:0] cnt;
	logic [2:0] zb;

	always_comb begin
		mask = '0;
		for (int k = 0; k < 8; k++) begin
			mask[k] = (3'(k) >= lo) && (3'(k) <= hi);
		end
		hits = data & mask;
		cnt  = '0;
		for (int k = 0; k < 8; k++) begin
			cnt = cnt + 4'(hits[k]);
		end
		// lowest zero bit wins
		zb = '0;
		for (int k = 7; k >= 0; k--) begin
			if (!data[k]) begin
				zb = 3'(k);
			end
		end
	end

	always_comb begin
		res.set_byte = data | (8'd1 << zb);
		res.clr_byte = data & ~mask;
		res.zero_bit = zb;
		res.hit_cnt  = cnt;
		res.all_ones = &data;
	end

endmodule

// ===== sv/bitmap_page_frame_allocator.sv =====
`timescale 1ns / 1ps

// Channel     | Ports                                               | Handshake
// ------------+-----------------------------------------------------+---------------------------
// request     | req_type, page_address, range_base, range_length    | start high while busy low
// result      | alloc_address, status, free_count                   | done strobe, one cycle
// config      | cfg_index, cfg_data                                 | cfg_valid and cfg_ready
//
// After reset a clearing pass writes every bitmap byte to all ones, with busy high
// (config writes are still taken). Allocate scans upward from the first-free hint, byte
// by byte, until it finds a byte with a zero bit or passes the bitmap in use; release
// checks and evaluates a single byte; a range free runs its setup states and then walks
// every bitmap byte it touches. The single-port read path of the bitmap RAM and the
// shared byte unit set this pace: each byte is read, evaluated and written back in turn.
// An unknown request answers at once and changes nothing.
// The result is shown for exactly one cycle with done; the receiver cannot stall it.

module bitmap_page_frame_allocator
	import bpfa_pkg::*;
#(
	parameter int unsigned BITMAP_DEPTH = DEPTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	// request transaction
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  req_type,
	input  logic [31:0] page_address,
	input  logic [31:0] range_base,
	input  logic [32:0] range_length,
	// result transaction
	output logic        done,
	output logic [27:0] alloc_address,
	output logic [1:0]  status,
	output logic [16:0] free_count,
	// configuration transaction
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [16:0] cfg_data
);

	localparam int unsigned AW = (BITMAP_DEPTH > 1) ? $clog2(BITMAP_DEPTH) : 1;
	localparam logic [BYTE_IDX_W-1:0] DEPTH_B = BYTE_IDX_W'(BITMAP_DEPTH);
	localparam logic [BYTE_IDX_W-1:0] LAST_B  = BYTE_IDX_W'(BITMAP_DEPTH - 1);
	localparam logic [20:0] PAGE_LIMIT = 21'h100000;   // 4 GiB in pages

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_A_CHK,
		S_A_EVAL,
		S_R_CHK,
		S_R_EVAL,
		S_F_SET1,
		S_F_SET2,
		S_F_SET3,
		S_F_RD,
		S_F_EVAL
	} state_t;

	state_t                 state_q;
	logic [BYTE_IDX_W-1:0]  ptr_q;       // current bitmap byte
	logic [BYTE_IDX_W-1:0]  last_q;      // last byte of a range walk
	logic [BYTE_IDX_W-1:0]  hint_q;      // every byte below it is full
	logic [2:0]             lo_q;
	logic [2:0]             hi_bit_q;
	logic [31:0]            base_q;
	logic [32:0]            length_q;
	logic [20:0]            bp_q;        // aligned base, in pages
	logic [20:0]            lp_q;        // trimmed length, in pages
	logic [20:0]            sum_q;       // range end clipped to 4 GiB
	logic [FREE_W-1:0]      free_q;
	logic [13:0]            bitmap_bytes_q;
	logic [16:0]            reserved_q;
	logic                   done_q;
	logic [27:0]            alloc_address_q;
	bpfa_status_t           status_q;

	// bitmap RAM and shared byte unit
	logic                   ram_we;
	logic [AW-1:0]          ram_addr;
	logic [7:0]             ram_wdata;
	logic [7:0]             ram_rdata;
	logic [2:0]             unit_hi;
	bpfa_byte_res_t         unit_res;

	// combinational helpers
	logic [BYTE_IDX_W-1:0]  active;
	logic [17:0]            free_sum;
	logic [FREE_W-1:0]      free_up;
	logic [12:0]            gap;
	logic [33:0]            len_diff;
	logic [20:0]            bp_calc;
	logic [21:0]            range_end;
	logic [20:0]            lim_pages;
	logic [20:0]            end_pages;
	logic [20:0]            end_m1;

	assign ram_addr = ptr_q[AW-1:0];

	bpfa_bitmap_ram #(
		.DEPTH (BITMAP_DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_addr),
		.wdata (ram_wdata),
		.raddr (ram_addr),
		.rdata (ram_rdata)
	);

	bpfa_byte_unit u_byte (
		.data (ram_rdata),
		.lo   (lo_q),
		.hi   (unit_hi),
		.res  (unit_res)
	);

	// Only the last byte of a range walk stops short of bit 7.
	assign unit_hi = (state_q == S_F_EVAL && ptr_q != last_q) ? 3'd7 : hi_bit_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_wdata = unit_res.clr_byte;
		unique case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_wdata = 8'hFF;
			end
			S_A_EVAL: begin
				ram_we    = !unit_res.all_ones;
				ram_wdata = unit_res.set_byte;
			end
			S_R_EVAL: ram_we = (unit_res.hit_cnt != 4'd0);
			S_F_EVAL: ram_we = 1'b1;
			default:  ram_we = 1'b0;
		endcase
	end

	// Bitmap bytes in use stop at the smaller of the register and the RAM depth.
	assign active = (BYTE_IDX_W'(bitmap_bytes_q) > DEPTH_B) ? DEPTH_B
		: BYTE_IDX_W'(bitmap_bytes_q);

	// Free count grows by the bits that really went from one to zero, saturating.
	assign free_sum = {1'b0, free_q} + 18'(unit_res.hit_cnt);
	assign free_up  = free_sum[17] ? FREE_MAX : free_sum[FREE_W-1:0];

	// Range setup: align the base up to a page and trim the length by the gap.
	assign gap      = (base_q[11:0] == 12'd0) ? 13'd0 : 13'd4096 - {1'b0, base_q[11:0]};
	assign len_diff = {1'b0, length_q} - 34'(gap);
	assign bp_calc  = (base_q[11:0] == 12'd0) ? {1'b0, base_q[31:PAGE_SHIFT]}
		: {1'b0, base_q[31:PAGE_SHIFT]} + 21'd1;

	assign range_end = {1'b0, bp_q} + {1'b0, lp_q};
	assign lim_pages = {active, 3'b000};
	assign end_pages = (sum_q < lim_pages) ? sum_q : lim_pages;
	assign end_m1    = end_pages - 21'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_CLEAR;
			ptr_q           <= '0;
			last_q          <= '0;
			hint_q          <= DEPTH_B;
			lo_q            <= '0;
			hi_bit_q        <= '0;
			base_q          <= '0;
			length_q        <= '0;
			bp_q            <= '0;
			lp_q            <= '0;
			sum_q           <= '0;
			free_q          <= '0;
			bitmap_bytes_q  <= BITMAP_BYTES_RESET;
			reserved_q      <= RESERVED_PAGES_RESET;
			done_q          <= 1'b0;
			alloc_address_q <= '0;
			status_q        <= ST_OK;
		end else begin
			done_q <= 1'b0;

			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_BITMAP_BYTES:   bitmap_bytes_q <= cfg_data[13:0];
					CFG_RESERVED_PAGES: reserved_q     <= cfg_data;
					default:            ;
				endcase
			end

			unique case (state_q)
				S_CLEAR: begin
					// sweep every byte to all ones
					if (ptr_q == LAST_B) begin
						ptr_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						ptr_q <= ptr_q + BYTE_IDX_W'(1);
					end
				end

				S_IDLE: begin
					if (start) begin
						alloc_address_q <= '0;
						unique case (req_type)
							REQ_ALLOC: begin
								ptr_q   <= hint_q;
								state_q <= S_A_CHK;
							end
							REQ_RELEASE: begin
								ptr_q    <= BYTE_IDX_W'(page_address[31:PAGE_SHIFT+3]);
								lo_q     <= page_address[PAGE_SHIFT+2:PAGE_SHIFT];
								hi_bit_q <= page_address[PAGE_SHIFT+2:PAGE_SHIFT];
								state_q  <= S_R_CHK;
							end
							REQ_FREE_RANGE: begin
								base_q   <= range_base;
								length_q <= range_length;
								state_q  <= S_F_SET1;
							end
							default: begin
								// unknown request: answer at once, change nothing
								status_q <= ST_OK;
								done_q   <= 1'b1;
							end
						endcase
					end
				end

				// Allocate: scan upward from the hint for a byte with a zero bit.
				S_A_CHK: begin
					if (ptr_q >= active) begin
						status_q <= ST_NO_FREE;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_A_EVAL;
					end
				end

				S_A_EVAL: begin
					if (unit_res.all_ones) begin
						ptr_q   <= ptr_q + BYTE_IDX_W'(1);
						state_q <= S_A_CHK;
					end else begin
						hint_q          <= ptr_q;
						free_q          <= (free_q != '0) ? free_q - FREE_W'(1) : free_q;
						alloc_address_q <= {ptr_q[12:0], unit_res.zero_bit, 12'h000};
						status_q        <= ST_OK;
						done_q          <= 1'b1;
						state_q         <= S_IDLE;
					end
				end

				// Release: page must lie in the bitmap and be in use.
				S_R_CHK: begin
					if (ptr_q >= active) begin
						status_q <= ST_BAD_RELEASE;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_R_EVAL;
					end
				end

				S_R_EVAL: begin
					if (unit_res.hit_cnt == 4'd0) begin
						status_q <= ST_BAD_RELEASE;
					end else begin
						status_q <= ST_OK;
						free_q   <= free_up;
						if (ptr_q < hint_q) begin
							hint_q <= ptr_q;
						end
					end
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end

				// Range free: align and trim.
				S_F_SET1: begin
					bp_q    <= bp_calc;
					lp_q    <= (len_diff[33] || len_diff == 34'd0) ? 21'd0
						: len_diff[32:PAGE_SHIFT];
					state_q <= S_F_SET2;
				end

				// Drop ranges past 4 GiB or starting in the reserved region; clip to 4 GiB.
				S_F_SET2: begin
					priority if (bp_q[20]) begin
						status_q <= ST_OK;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else if (bp_q < {4'b0000, reserved_q}) begin
						status_q <= (range_end > {5'b00000, reserved_q}) ? ST_RESERVED : ST_OK;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						sum_q   <= (range_end > {1'b0, PAGE_LIMIT}) ? PAGE_LIMIT
							: range_end[20:0];
						state_q <= S_F_SET3;
					end
				end

				// Clip to the bitmap in use and set up the byte walk.
				S_F_SET3: begin
					if (end_pages <= bp_q) begin
						status_q <= ST_OK;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						ptr_q    <= BYTE_IDX_W'(bp_q[20:3]);
						last_q   <= BYTE_IDX_W'(end_m1[20:3]);
						lo_q     <= bp_q[2:0];
						hi_bit_q <= end_m1[2:0];
						if (BYTE_IDX_W'(bp_q[20:3]) < hint_q) begin
							hint_q <= BYTE_IDX_W'(bp_q[20:3]);
						end
						state_q  <= S_F_RD;
					end
				end

				S_F_RD: state_q <= S_F_EVAL;

				S_F_EVAL: begin
					free_q <= free_up;
					if (ptr_q == last_q) begin
						status_q <= ST_OK;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						// later bytes start at bit 0
						ptr_q   <= ptr_q + BYTE_IDX_W'(1);
						lo_q    <= 3'd0;
						state_q <= S_F_RD;
					end
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy          = (state_q != S_IDLE);
	assign cfg_ready     = 1'b1;
	assign done          = done_q;
	assign alloc_address = alloc_address_q;
	assign status        = status_q;
	assign free_count    = free_q;

endmodule
